### design/irct_pkg.sv
// Shared types and codes for the in-flight range conflict table.
// Holds the request and result transaction structs, the scan token and the commit command.
// No dependencies; every other file in this folder imports it.
package irct_pkg;

    // Request kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes
    localparam logic [2:0] STATUS_ADDED     = 3'd0;
    localparam logic [2:0] STATUS_OVERLAP   = 3'd1;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_REMOVED   = 3'd4;

    // Width of the reported count field
    localparam int unsigned COUNT_OUT_W = 5;

    typedef struct packed {
        logic        kind;
        logic [63:0] request_id;
        logic [63:0] range_start;
        logic [63:0] range_end;
    } irct_req_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [COUNT_OUT_W-1:0] in_flight_count;
    } irct_rsp_t;

    // Token walking down the chain, gathering what the cells have seen
    typedef struct packed {
        logic active;
        logic overlap;
        logic dup;
        logic free;
    } irct_tok_t;

    // Commit command broadcast to all cells once the scan has finished
    typedef struct packed {
        logic wr;
        logic clr;
    } irct_cmd_t;

endpackage

### design/irct_cell.sv
// One entry of the in-flight range conflict table, as a cell of the scan chain.
// Compares its entry with the current request and passes the token on to its neighbour.
// Depends on irct_pkg.
module irct_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  irct_pkg::irct_req_t req,
    input  irct_pkg::irct_tok_t tok_in,
    input  irct_pkg::irct_cmd_t cmd,
    output irct_pkg::irct_tok_t tok_out
);
    import irct_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] id_reg;
    logic [63:0] first_reg;
    logic [63:0] last_reg;
    logic        pick_free_reg;
    logic        pick_free_next;
    logic        pick_id_reg;
    logic        pick_id_next;
    irct_tok_t   tok_reg;
    irct_tok_t   tok_next;
    logic        hit_range;
    logic        hit_id;
    logic        do_write;

    // Compare the stored entry with the request
    assign hit_range = valid_reg && (last_reg >= req.range_start)
                       && (first_reg <= req.range_end);
    assign hit_id    = valid_reg && (id_reg == req.request_id);
    assign do_write  = cmd.wr && pick_free_reg;

    // Merge this cell's findings into the token, mark this cell as a target and apply a commit to its valid bit
    always_comb
    begin
        tok_next.active = tok_in.active;
        tok_next.overlap = tok_in.overlap | hit_range;
        tok_next.dup = tok_in.dup | hit_id;
        tok_next.free = tok_in.free | !valid_reg;
        pick_free_next = pick_free_reg;
        pick_id_next = pick_id_reg;
        if (tok_in.active)
        begin
            pick_free_next = !tok_in.free && !valid_reg;
            pick_id_next = !tok_in.dup && hit_id;
        end
        valid_next = valid_reg;
        if (do_write)
        begin
            valid_next = 1'b1;
        end
        else if (cmd.clr && pick_id_reg)
        begin
            valid_next = 1'b0;
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pick_free_reg <= 1'b0;
            pick_id_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pick_free_reg <= pick_free_next;
            pick_id_reg <= pick_id_next;
            tok_reg <= tok_next;
        end
    end

    // Store the entry payload on an admitted add
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            id_reg <= req.request_id;
            first_reg <= req.range_start;
            last_reg <= req.range_end;
        end
    end

    assign tok_out = tok_reg;

endmodule

### design/inflight_range_conflict_table_unit.sv
// done is registered once the scan token has passed the register of every table cell.
// No new transaction is taken while busy; a new start is taken in the done cycle.
// The scan token visits one table cell per cycle.
// Reset clears all entry valid bits and the count at once; no clearing pass is needed.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Top level of the in-flight range conflict table; depends on irct_pkg and irct_cell.
module inflight_range_conflict_table_unit #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  irct_pkg::irct_req_t request,
    output logic                done,
    output irct_pkg::irct_rsp_t result
);
    import irct_pkg::*;

    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam logic        ST_IDLE = 1'b0;
    localparam logic        ST_SCAN = 1'b1;

    logic             state_reg;
    logic             state_next;
    irct_req_t        req_reg;
    logic             launch_reg;
    logic             launch_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    irct_rsp_t        rsp_reg;
    irct_rsp_t        rsp_next;
    irct_cmd_t        cmd;
    irct_tok_t        tok_w [ENTRIES+1];
    irct_tok_t        tok_last;
    logic             accept;
    logic             finish;

    assign accept = start && (state_reg == ST_IDLE);

    // Launch a fresh token into the first cell the cycle after acceptance
    assign tok_w[0] = '{active: launch_reg, overlap: 1'b0, dup: 1'b0, free: 1'b0};

    // Chain of table cells
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            irct_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .req     (req_reg),
                .tok_in  (tok_w[gi]),
                .cmd     (cmd),
                .tok_out (tok_w[gi+1])
            );
        end
    endgenerate

    assign tok_last = tok_w[ENTRIES];
    assign finish   = (state_reg == ST_SCAN) && tok_last.active;

    // Decide the outcome once the token leaves the last cell
    always_comb
    begin
        state_next = state_reg;
        launch_next = accept;
        count_next = count_reg;
        done_next = 1'b0;
        rsp_next = rsp_reg;
        cmd.wr = 1'b0;
        cmd.clr = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                    done_next = 1'b1;
                    if (req_reg.kind == KIND_ADD)
                    begin
                        if (tok_last.overlap)
                        begin
                            rsp_next.status = STATUS_OVERLAP;
                        end
                        else if (tok_last.dup)
                        begin
                            rsp_next.status = STATUS_DUPLICATE;
                        end
                        else if (!tok_last.free)
                        begin
                            rsp_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            rsp_next.status = STATUS_ADDED;
                            cmd.wr = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.status = STATUS_REMOVED;
                        if (tok_last.dup)
                        begin
                            cmd.clr = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    rsp_next.in_flight_count = COUNT_OUT_W'(count_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            launch_reg <= 1'b0;
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            launch_reg <= launch_next;
            count_reg <= count_next;
            done_reg <= done_next;
        end
    end

    // Capture the request transaction and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        rsp_reg <= rsp_next;
    end

    assign busy   = (state_reg == ST_SCAN);
    assign done   = done_reg;
    assign result = rsp_reg;

    // The result strobe only appears once the table is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // An accepted transaction always occupies the table
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start a scan");

    // Every finished scan yields exactly one result in the next cycle
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> done)
        else $error("scan finished without a result");

    // Never store and free in the same commit
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr, cmd.clr}))
        else $error("conflicting commit command");

    // The count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count exceeds table size");

endmodule

### tb/tb.sv
// Self-checking testbench for inflight_range_conflict_table_unit.
// Mirrors the table in a local predictor and checks each done result against it.
// Depends on irct_pkg and the top-level RTL only.
module tb;
    import irct_pkg::*;

    localparam int unsigned TABLE_SIZE  = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam logic [63:0] ALL_ONES    = '1;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    irct_req_t request;
    logic      done;
    irct_rsp_t result;

    // Shadow copy of the conflict table
    bit          slot_used  [TABLE_SIZE];
    logic [63:0] slot_id    [TABLE_SIZE];
    logic [63:0] slot_first [TABLE_SIZE];
    logic [63:0] slot_last  [TABLE_SIZE];
    int unsigned slot_count;

    irct_rsp_t   pending_results[$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned sent_count;
    bit          gaps_on;
    logic [63:0] id_base;
    logic [63:0] block_base;

    inflight_range_conflict_table_unit #(
        .ENTRIES(TABLE_SIZE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic irct_req_t make_req(input logic kind, input logic [63:0] id,
                                           input logic [63:0] lo, input logic [63:0] hi);
        irct_req_t item;
        item.kind        = kind;
        item.request_id  = id;
        item.range_start = lo;
        item.range_end   = hi;
        return item;
    endfunction

    // Apply one transaction to the shadow table and return the expected result
    function automatic irct_rsp_t table_apply(input irct_req_t item);
        irct_rsp_t rsp;
        bit        clash;
        int        hit;
        int        free_slot;
        clash     = 1'b0;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_used[i] && slot_last[i] >= item.range_start &&
                slot_first[i] <= item.range_end)
                clash = 1'b1;
            if (slot_used[i] && slot_id[i] == item.request_id && hit < 0)
                hit = i;
            if (!slot_used[i] && free_slot < 0)
                free_slot = i;
        end
        if (item.kind == KIND_ADD)
        begin
            if (clash)
                rsp.status = STATUS_OVERLAP;
            else if (hit >= 0)
                rsp.status = STATUS_DUPLICATE;
            else if (free_slot < 0)
                rsp.status = STATUS_FULL;
            else
            begin
                slot_used[free_slot]  = 1'b1;
                slot_id[free_slot]    = item.request_id;
                slot_first[free_slot] = item.range_start;
                slot_last[free_slot]  = item.range_end;
                slot_count++;
                rsp.status = STATUS_ADDED;
            end
        end
        else
        begin
            if (hit >= 0)
            begin
                slot_used[hit] = 1'b0;
                slot_count--;
            end
            rsp.status = STATUS_REMOVED;
        end
        rsp.in_flight_count = slot_count[COUNT_OUT_W-1:0];
        return rsp;
    endfunction

    // Pick the id of a random stored entry; the caller makes sure one exists
    function automatic logic [63:0] live_id_pick();
        int unsigned k;
        k = $urandom_range(0, slot_count - 1);
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_used[i])
            begin
                if (k == 0)
                    return slot_id[i];
                k--;
            end
        end
        return id_base;
    endfunction

    // Add near the current id pool and block region, sometimes reversed or wide
    function automatic irct_req_t add_near(input int unsigned spread, input int unsigned len);
        logic [63:0] lo;
        logic [63:0] hi;
        int unsigned pick;
        pick = $urandom_range(0, 31);
        lo   = block_base + 64'($urandom_range(0, spread));
        hi   = lo + 64'($urandom_range(0, len));
        if (pick == 0)
        begin
            lo = rand64();
            hi = rand64();
        end
        else if (pick < 3)
            return make_req(KIND_ADD, id_base + 64'($urandom_range(0, 47)), hi + 1, lo);
        return make_req(KIND_ADD, id_base + 64'($urandom_range(0, 47)), lo, hi);
    endfunction

    // Remove a stored id most of the time, otherwise one that is likely absent
    function automatic irct_req_t remove_some();
        logic [63:0] id;
        if (slot_count > 0 && $urandom_range(0, 4) != 0)
            id = live_id_pick();
        else
            id = id_base + 64'($urandom_range(0, 63));
        return make_req(KIND_REMOVE, id, rand64(), rand64());
    endfunction

    // Present one transaction, hold it until accepted, then log its expectation
    task automatic issue_request(input irct_req_t item);
        int unsigned gap;
        bit          wait_idle;
        sent_count++;
        if (sent_count % 32 == 0)
            gaps_on = ($urandom_range(0, 3) != 0);
        gap       = gaps_on ? $urandom_range(0, 8) : 0;
        wait_idle = gaps_on && ($urandom_range(0, 1) == 1);
        @(negedge clk);
        if (gap > 0 || wait_idle)
        begin
            start   <= 1'b0;
            request <= make_req(1'($urandom_range(0, 1)), rand64(), rand64(), rand64());
            if (wait_idle)
            begin
                do
                    @(posedge clk);
                while (busy);
            end
            repeat (gap) @(negedge clk);
            if (gap == 0)
                @(negedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(table_apply(item));
    endtask

    task automatic stop_requests();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Check each done strobe against the oldest pending expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d count %0d",
                       result.status, result.in_flight_count);
                fail_count++;
            end
            else
            begin
                irct_rsp_t want;
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.in_flight_count !== want.in_flight_count)
                begin
                    $error("in_flight_count: expected %0d, actual %0d",
                           want.in_flight_count, result.in_flight_count);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Edge values, check precedence, reversed ranges and removes of absent ids
    task automatic test_directed_cases();
        gaps_on = 1'b0;
        issue_request(make_req(KIND_REMOVE, 64'd5, 64'd0, 64'd0));
        issue_request(make_req(KIND_ADD, 64'd0, 64'd0, 64'd0));
        issue_request(make_req(KIND_ADD, ALL_ONES, ALL_ONES, ALL_ONES));
        issue_request(make_req(KIND_ADD, 64'd1, 64'd0, ALL_ONES));
        issue_request(make_req(KIND_ADD, 64'd0, 64'd10, 64'd20));
        // overlap wins over duplicate id
        issue_request(make_req(KIND_ADD, 64'd0, 64'd0, 64'd5));
        // reversed range stored as given
        issue_request(make_req(KIND_ADD, 64'd2, 64'd25, 64'd20));
        issue_request(make_req(KIND_ADD, 64'd3, 64'd22, 64'd22));
        issue_request(make_req(KIND_ADD, 64'd4, 64'd18, 64'd30));
        // remove ignores the range fields
        issue_request(make_req(KIND_REMOVE, 64'd2, ALL_ONES, ALL_ONES));
        issue_request(make_req(KIND_REMOVE, 64'd2, 64'd0, 64'd0));
        issue_request(make_req(KIND_ADD, 64'd4, 64'd23, 64'd30));
        issue_request(make_req(KIND_REMOVE, ALL_ONES, 64'd0, 64'd0));
        issue_request(make_req(KIND_ADD, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000,
                               64'hAAAA_AAAA_AAAA_AAAA));
        issue_request(make_req(KIND_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 64'd1, 64'd1));
        issue_request(make_req(KIND_ADD, 64'd9, ALL_ONES - 1, ALL_ONES - 1));
    endtask

    // Mixed adds and removes on a crowded block region
    task automatic test_random_churn();
        for (int n = 0; n < 450; n++)
        begin
            if (n % 100 == 0)
            begin
                id_base    = rand64();
                block_base = rand64();
            end
            if (slot_count > 0 && $urandom_range(0, 99) < 40)
                issue_request(remove_some());
            else
                issue_request(add_near(255, 12));
        end
    endtask

    // Fill the table to the brim, push past it, then drain part of it
    task automatic test_fill_and_drain();
        int unsigned issued;
        int unsigned drain;
        issued = 0;
        while (issued < 450)
        begin
            id_base    = rand64();
            block_base = rand64();
            while (slot_count < TABLE_SIZE && issued < 450)
            begin
                issue_request(add_near(1023, 3));
                issued++;
            end
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 2))
                    0: issue_request(make_req(KIND_ADD, rand64(), rand64() | 64'd1, 64'd0));
                    1: issue_request(make_req(KIND_ADD, live_id_pick(), 64'd0, 64'd0));
                    default: issue_request(add_near(1023, 3));
                endcase
                issued++;
            end
            drain = $urandom_range(4, TABLE_SIZE + 2);
            repeat (drain)
            begin
                issue_request(remove_some());
                issued++;
            end
        end
    endtask

    // Random field values; the id is a stored one about half the time when the table is not empty
    task automatic test_field_noise();
        logic [63:0] id;
        for (int n = 0; n < 200; n++)
        begin
            id = (slot_count > 0 && $urandom_range(0, 1) == 1) ? live_id_pick() : rand64();
            issue_request(make_req(1'($urandom_range(0, 1)), id, rand64(), rand64()));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        fail_count  = 0;
        cycle_count = 0;
        sent_count  = 0;
        gaps_on     = 1'b1;
        slot_count  = 0;
        id_base     = '0;
        block_base  = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_id[i]    = '0;
            slot_first[i] = '0;
            slot_last[i]  = '0;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_churn();
        test_fill_and_drain();
        test_field_noise();
        stop_requests();

        // Drain outstanding results, then watch for stray strobes
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### inflight_range_conflict_table_unit.f
design/irct_pkg.sv
design/irct_cell.sv
design/inflight_range_conflict_table_unit.sv
tb/tb.sv
